### rtl/core/chull_pkg.sv
// Shared types, constants and controller states of the convex hull core.
`timescale 1ns / 1ps
package chull_pkg;

  localparam int MAX_POINTS_DEF  = 32;
  localparam int COORD_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOAD,
    S_MUL,
    S_CMP,
    S_SKIP,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ins;      // accept one point request
    logic start;    // last point seen: latch set, clear accumulators
    logic load;     // take the next sorted point into the probe register
    logic upper;    // upper chain in progress
    logic skip;     // drop the rightmost point before the upper chain
    logic pop;      // pop the stack top
    logic push;     // push the probe point
    logic set_lim;  // latch the pop limit for the upper chain
    logic rd_emit;  // address the stack memory by the emit index
    logic emit;     // load one vertex into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic few;        // set holds one or two points
    logic pop_ok;     // stack deep enough and turn not strictly ccw
    logic out_free;   // output register can take a vertex
    logic emit_last;  // current emit index is the final vertex
  } status_t;

endpackage

### rtl/core/chull_ctrl.sv
// Sequencer of the convex hull core: collect, chain passes, vertex emission.
`timescale 1ns / 1ps
module chull_ctrl #(
  parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  input  chull_pkg::status_t status,
  input  logic [CNT_W-1:0]   nset,
  output chull_pkg::cmd_t    cmd,
  output logic [CNT_W-1:0]   e
);
  import chull_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] rem;
  logic             upper;
  logic             chain_end;

  assign chain_end = (rem == CNT_W'(1));

  // State register and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rem   <= '0;
      upper <= 1'b0;
      e     <= '0;
    end else begin
      state <= state_next;
      if (state == S_START) begin
        rem   <= nset;
        upper <= 1'b0;
        e     <= '0;
      end
      if (cmd.push) begin
        if (chain_end && !upper) begin
          upper <= 1'b1;
          rem   <= nset - CNT_W'(1);
        end else begin
          rem <= rem - CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        e <= e + CNT_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (s_tvalid && s_tlast) state_next = S_START;
      S_START:    state_next = status.few ? S_EMIT_RD : S_LOAD;
      S_LOAD:     state_next = S_MUL;
      S_MUL:      state_next = S_CMP;
      S_CMP: begin
        if (status.pop_ok) state_next = S_MUL;
        else if (chain_end) state_next = upper ? S_EMIT_RD : S_SKIP;
        else state_next = S_LOAD;
      end
      S_SKIP:     state_next = S_LOAD;
      S_EMIT_RD:  state_next = S_EMIT_PUT;
      S_EMIT_PUT: begin
        if (status.out_free) state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    s_tready    = (state == S_IDLE);
    cmd         = '0;
    cmd.ins     = (state == S_IDLE) && s_tvalid;
    cmd.start   = cmd.ins && s_tlast;
    cmd.load    = (state == S_LOAD);
    cmd.upper   = upper;
    cmd.skip    = (state == S_SKIP);
    cmd.pop     = (state == S_CMP) && status.pop_ok;
    cmd.push    = (state == S_CMP) && !status.pop_ok;
    cmd.set_lim = cmd.push && chain_end && !upper;
    cmd.rd_emit = (state == S_EMIT_RD) || (state == S_EMIT_PUT);
    cmd.emit    = (state == S_EMIT_PUT) && status.out_free;
  end

endmodule

### rtl/core/chull_dp.sv
// Datapath: sorted point row, turn test, hull stack memory, output register.
`timescale 1ns / 1ps
module chull_dp #(
  parameter int MAX_POINTS  = chull_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = chull_pkg::COORD_WIDTH_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chull_pkg::cmd_t               cmd,
  input  logic [CNT_W-1:0]              e,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  output chull_pkg::status_t            status,
  output logic [CNT_W-1:0]              nset,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_last,
  output logic                          out_ovf
);
  import chull_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int SPW = $clog2(MAX_POINTS + 2);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int PW  = 2 * CW + 2;

  logic signed [CW-1:0] row_x [MAX_POINTS];
  logic signed [CW-1:0] row_y [MAX_POINTS];
  logic signed [CW-1:0] rev_x [MAX_POINTS];
  logic signed [CW-1:0] rev_y [MAX_POINTS];
  logic signed [CW-1:0] ins_x [MAX_POINTS];
  logic signed [CW-1:0] ins_y [MAX_POINTS];
  logic [MAX_POINTS-1:0] less;

  logic [CNT_W-1:0]     cnt;
  logic                 ovf_acc, ovf_set;
  logic                 full;
  logic signed [CW-1:0] f0x, f0y, f1x, f1y;
  logic signed [CW-1:0] rx, ry, ax, ay, bx, by;
  logic [SPW-1:0]       sp, lim, sp_push, sp_m2, sp_m3;
  logic                 can_push;
  logic [2*CW-1:0]      mem [MAX_POINTS];
  logic [2*CW-1:0]      rd;
  logic [AW-1:0]        rd_addr;
  logic signed [CW:0]   dy1, dx2, dx1, dy2;
  logic signed [PW-1:0] pa, pb;

  assign full = (cnt == CNT_W'(MAX_POINTS));

  // Sorted insertion: every entry greater than the new point moves up one place
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      less[k] = (CNT_W'(k) < cnt) &&
                ((in_x < row_x[k]) || ((in_x == row_x[k]) && (in_y < row_y[k])));
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (less[k]) begin
        if (k == 0 || !less[(k == 0) ? 0 : k - 1]) begin
          ins_x[k] = in_x;
          ins_y[k] = in_y;
        end else begin
          ins_x[k] = row_x[(k == 0) ? 0 : k - 1];
          ins_y[k] = row_y[(k == 0) ? 0 : k - 1];
        end
      end else if (CNT_W'(k) == cnt) begin
        // Take the shifted top entry, or the new point when it is the largest
        if (k != 0 && less[(k == 0) ? 0 : k - 1]) begin
          ins_x[k] = row_x[(k == 0) ? 0 : k - 1];
          ins_y[k] = row_y[(k == 0) ? 0 : k - 1];
        end else begin
          ins_x[k] = in_x;
          ins_y[k] = in_y;
        end
      end else begin
        ins_x[k] = row_x[k];
        ins_y[k] = row_y[k];
      end
    end
  end

  // Sorted row and its reversed copy for the upper chain
  always_ff @(posedge clk) begin
    if (cmd.ins && !full) begin
      row_x <= ins_x;
      row_y <= ins_y;
    end else if (cmd.load && !cmd.upper) begin
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
        row_x[k] <= row_x[k+1];
        row_y[k] <= row_y[k+1];
      end
      rev_x[0] <= row_x[0];
      rev_y[0] <= row_y[0];
      for (int k = 1; k < MAX_POINTS; k++) begin
        rev_x[k] <= rev_x[k-1];
        rev_y[k] <= rev_y[k-1];
      end
    end else if ((cmd.load && cmd.upper) || cmd.skip) begin
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
        rev_x[k] <= rev_x[k+1];
        rev_y[k] <= rev_y[k+1];
      end
    end
  end

  assign can_push = (sp < SPW'(MAX_POINTS + 1));
  assign sp_push  = can_push ? sp + SPW'(1) : sp;
  assign sp_m2    = sp - SPW'(2);
  assign sp_m3    = sp - SPW'(3);

  // Set bookkeeping and stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      ovf_acc <= 1'b0;
      sp      <= '0;
      lim     <= SPW'(2);
      nset    <= '0;
      ovf_set <= 1'b0;
    end else begin
      if (cmd.start) begin
        nset    <= full ? cnt : cnt + CNT_W'(1);
        ovf_set <= ovf_acc | full;
        cnt     <= '0;
        ovf_acc <= 1'b0;
        sp      <= '0;
        lim     <= SPW'(2);
      end else if (cmd.ins) begin
        if (full) ovf_acc <= 1'b1;
        else cnt <= cnt + CNT_W'(1);
      end
      if (cmd.pop) sp <= sp - SPW'(1);
      if (cmd.push) sp <= sp_push;
      if (cmd.set_lim) lim <= sp_push + SPW'(1);
    end
  end

  // First two arrivals, probe point and the two stack tops
  always_ff @(posedge clk) begin
    if (cmd.ins && cnt == CNT_W'(0)) begin
      f0x <= in_x;
      f0y <= in_y;
    end
    if (cmd.ins && cnt == CNT_W'(1)) begin
      f1x <= in_x;
      f1y <= in_y;
    end
    if (cmd.load) begin
      rx <= cmd.upper ? rev_x[0] : row_x[0];
      ry <= cmd.upper ? rev_y[0] : row_y[0];
    end
    if (cmd.pop) begin
      bx <= ax;
      by <= ay;
      ax <= rd[CW-1:0];
      ay <= rd[2*CW-1:CW];
    end else if (cmd.push && can_push) begin
      ax <= bx;
      ay <= by;
      bx <= rx;
      by <= ry;
    end
  end

  // Stack entries below the two tops live in memory
  assign rd_addr = cmd.rd_emit ? e[AW-1:0] : sp_m3[AW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.push && can_push && sp >= SPW'(2)) begin
      mem[sp_m2[AW-1:0]] <= {ay, ax};
    end
    rd <= mem[rd_addr];
  end

  // Cross product terms, registered before the compare
  assign dy1 = (CW+1)'(by) - (CW+1)'(ay);
  assign dx2 = (CW+1)'(rx) - (CW+1)'(bx);
  assign dx1 = (CW+1)'(bx) - (CW+1)'(ax);
  assign dy2 = (CW+1)'(ry) - (CW+1)'(by);
  always_ff @(posedge clk) begin
    pa <= dy1 * dx2;
    pb <= dx1 * dy2;
  end

  assign status.few       = (nset <= CNT_W'(2));
  assign status.pop_ok    = (sp >= lim) && !(pa < pb);
  assign status.out_free  = !m_tvalid || m_tready;
  assign status.emit_last = status.few ? (e == nset - CNT_W'(1))
                                       : (SPW'(e) == sp - SPW'(2));

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= status.emit_last;
      out_ovf  <= ovf_set;
      if (status.few) begin
        out_x <= (e == CNT_W'(0)) ? f0x : f1x;
        out_y <= (e == CNT_W'(0)) ? f0y : f1y;
      end else if (status.emit_last) begin
        out_x <= ax;
        out_y <= ay;
      end else begin
        out_x <= rd[CW-1:0];
        out_y <= rd[2*CW-1:CW];
      end
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(MAX_POINTS + 1))
    else $error("hull stack depth out of range");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_POINTS))
    else $error("point count out of range");
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> sp == $past(sp) - SPW'(1))
    else $error("pop did not lower the stack by one");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.emit)
    else $error("vertex loaded over a stalled vertex");

endmodule

### rtl/core/convex_hull_monotone_chain_core.sv
// Top level of the convex hull core: controller plus datapath.
`timescale 1ns / 1ps
// Convex hull of an integer point set, monotone chain method.
// Input channel s_*: one point per request; s_tlast marks the final point
// of a set. Each point is inserted into a sorted row as it is taken, so the
// core takes one point per cycle while collecting. Points beyond MAX_POINTS
// are dropped and the set's results carry the overflow flag in m_tuser.
// After the last point the core walks the lower and then the upper chain:
// 2*n - 1 chain steps for a set of n points, each a load, a multiply and a
// compare, with one more multiply and compare per pop, plus one start and
// one skip step.
// The hull vertices then leave on m_*, the final one with m_tlast. Sets
// of one or two points are sent back as received.
// s_tready is low from the last point of a set until its final vertex is
// loaded into the output register. A stalled receiver holds the output
// register and the core waits; no result is lost.
// Reset clears the point count, stack depth, overflow mark and the output valid flag.
module convex_hull_monotone_chain_core #(
  parameter int MAX_POINTS  = chull_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = chull_pkg::COORD_WIDTH_DEF,
  localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // point_x, point_y
  input  logic               s_tlast,   // last_point
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // vertex_x, vertex_y, zero fill
  output logic               m_tlast,   // last_vertex
  output logic               m_tuser    // overflow_flag
);
  import chull_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = COORD_WIDTH;

  cmd_t                 cmd;
  status_t              status;
  logic [CNT_W-1:0]     nset;
  logic [CNT_W-1:0]     e;
  logic signed [CW-1:0] out_x, out_y;

  chull_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .nset     (nset),
    .cmd      (cmd),
    .e        (e)
  );

  chull_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .e        (e),
    .in_x     (s_tdata[CW-1:0]),
    .in_y     (s_tdata[2*CW-1:CW]),
    .status   (status),
    .nset     (nset),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_last (m_tlast),
    .out_ovf  (m_tuser)
  );

  // Pack the vertex, zero fill above
  assign m_tdata = TDATA_W'({out_y, out_x});

endmodule
